>>> design/ccrs_pkg.sv
`timescale 1ns / 1ps
// Shared types, register indexes and reset values of the congestion control rate selector.
package ccrs_pkg;

    typedef enum logic [1:0] {
        DCC_RELAXED    = 2'd0,
        DCC_ACTIVE     = 2'd1,
        DCC_RESTRICTED = 2'd2
    } t_dcc_state;

    typedef enum logic [1:0] {
        KIND_TICK = 2'd0,
        KIND_PUSH = 2'd1,
        KIND_EVAL = 2'd2
    } t_item_kind;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_SCAN = 2'd1,
        BK_EVAL = 2'd2
    } t_back_state;

    typedef struct packed {
        logic [15:0] measure_ticks;
        logic [3:0]  up_window;
        logic [3:0]  down_window;
        logic [15:0] min_load_busy;
        logic [15:0] max_load_busy;
        logic [15:0] relaxed_interval;
        logic [15:0] active_interval;
        logic [15:0] restricted_interval;
    } t_cfg;

    localparam int KIND_WIDTH = 2;

    localparam logic [2:0] CFG_IDX_MEASURE_TICKS       = 3'd0;
    localparam logic [2:0] CFG_IDX_UP_WINDOW           = 3'd1;
    localparam logic [2:0] CFG_IDX_DOWN_WINDOW         = 3'd2;
    localparam logic [2:0] CFG_IDX_MIN_LOAD_BUSY       = 3'd3;
    localparam logic [2:0] CFG_IDX_MAX_LOAD_BUSY       = 3'd4;
    localparam logic [2:0] CFG_IDX_RELAXED_INTERVAL    = 3'd5;
    localparam logic [2:0] CFG_IDX_ACTIVE_INTERVAL     = 3'd6;
    localparam logic [2:0] CFG_IDX_RESTRICTED_INTERVAL = 3'd7;

    localparam logic [15:0] RST_MEASURE_TICKS       = 16'd1000;
    localparam logic [3:0]  RST_UP_WINDOW           = 4'd1;
    localparam logic [3:0]  RST_DOWN_WINDOW         = 4'd5;
    localparam logic [15:0] RST_MIN_LOAD_BUSY       = 16'd150;
    localparam logic [15:0] RST_MAX_LOAD_BUSY       = 16'd400;
    localparam logic [15:0] RST_RELAXED_INTERVAL    = 16'd40;
    localparam logic [15:0] RST_ACTIVE_INTERVAL     = 16'd500;
    localparam logic [15:0] RST_RESTRICTED_INTERVAL = 16'd1000;

    // Beacon interval of a state; a zero register acts as one tick.
    function automatic logic [15:0] sel_interval(t_cfg c, t_dcc_state s);
        logic [15:0] v;
        case (s)
            DCC_RELAXED:    v = c.relaxed_interval;
            DCC_ACTIVE:     v = c.active_interval;
            default:        v = c.restricted_interval;
        endcase
        return (v == 16'd0) ? 16'd1 : v;
    endfunction

endpackage

>>> design/ccrs_front.sv
`timescale 1ns / 1ps
// Front end: counts busy ticks per measurement and classifies each tick.
module ccrs_front import ccrs_pkg::*; #(
    parameter int COUNT_WIDTH = 16,
    parameter int EVAL_EVERY  = 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic                   i_channel_busy,
    output logic                   o_stall,
    input  logic [15:0]            i_measure_ticks,
    input  logic                   i_full,
    output logic                   o_push,
    output t_item_kind             o_kind,
    output logic [COUNT_WIDTH-1:0] o_sample
);

    localparam int EW = (EVAL_EVERY > 1) ? $clog2(EVAL_EVERY) : 1;

    logic [COUNT_WIDTH-1:0] r_busy_ticks, n_busy_ticks, bt_inc;
    logic [15:0]            r_tick_in_measure, n_tick_in_measure, tim_inc, meas_len;
    logic [EW-1:0]          r_meas_since_eval, n_meas_since_eval;
    logic                   accept;
    logic                   done;
    logic                   eval_due;

    always_comb begin
        accept   = i_valid && !i_full;
        bt_inc   = (i_channel_busy && (r_busy_ticks != '1))
                   ? r_busy_ticks + COUNT_WIDTH'(1) : r_busy_ticks;
        tim_inc  = (r_tick_in_measure != 16'hFFFF)
                   ? r_tick_in_measure + 16'd1 : r_tick_in_measure;
        meas_len = (i_measure_ticks == 16'd0) ? 16'd1 : i_measure_ticks;
        done     = tim_inc >= meas_len;
        eval_due = (int'(r_meas_since_eval) == EVAL_EVERY - 1);

        n_busy_ticks      = r_busy_ticks;
        n_tick_in_measure = r_tick_in_measure;
        n_meas_since_eval = r_meas_since_eval;
        o_kind            = KIND_TICK;
        o_sample          = '0;

        if (accept) begin
            n_busy_ticks      = bt_inc;
            n_tick_in_measure = tim_inc;
            if (done) begin
                n_busy_ticks      = '0;
                n_tick_in_measure = 16'd0;
                o_sample          = bt_inc;
                if (eval_due) begin
                    o_kind            = KIND_EVAL;
                    n_meas_since_eval = '0;
                end else begin
                    o_kind            = KIND_PUSH;
                    n_meas_since_eval = r_meas_since_eval + EW'(1);
                end
            end
        end
    end

    assign o_stall = i_full;
    assign o_push  = accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy_ticks      <= '0;
            r_tick_in_measure <= 16'd0;
            r_meas_since_eval <= '0;
        end else begin
            r_busy_ticks      <= n_busy_ticks;
            r_tick_in_measure <= n_tick_in_measure;
            r_meas_since_eval <= n_meas_since_eval;
        end
    end

endmodule

>>> design/ccrs_queue.sv
`timescale 1ns / 1ps
// Short queue of classified ticks between the front and back ends.
module ccrs_queue #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

>>> design/ccrs_back.sv
`timescale 1ns / 1ps
// Back end: sample ring, window scan, state evaluation, beacon timing and result register.
module ccrs_back import ccrs_pkg::*; #(
    parameter int WINDOW_DEPTH = 8,
    parameter int COUNT_WIDTH  = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cfg                   i_cfg,
    input  logic                   i_q_empty,
    input  t_item_kind             i_q_kind,
    input  logic [COUNT_WIDTH-1:0] i_q_sample,
    output logic                   o_q_pop,
    input  logic                   i_stall,
    output logic                   o_valid,
    output logic [1:0]             o_dcc_state,
    output logic [15:0]            o_beacon_interval,
    output logic                   o_beacon_now,
    output logic                   o_measure_done,
    output logic [15:0]            o_busy_sample
);

    localparam int PW = $clog2(WINDOW_DEPTH);
    localparam int HW = $clog2(WINDOW_DEPTH + 1);
    localparam int SW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

    logic [COUNT_WIDTH-1:0] r_ring [WINDOW_DEPTH];
    logic [COUNT_WIDTH-1:0] r_rd_data;

    t_back_state            r_bk_state, n_bk_state;
    t_dcc_state             r_rate_state, n_rate_state, eval_state, fin_state;
    logic [PW-1:0]          r_pos, n_pos, pos_inc, r_addr, n_addr;
    logic [HW-1:0]          r_held, n_held, held_inc;
    logic [HW-1:0]          r_scan_n, n_scan_n, scan_n;
    logic [HW-1:0]          r_up_len, n_up_len, up_len;
    logic [HW-1:0]          r_dn_len, n_dn_len, dn_len;
    logic [HW-1:0]          r_issue, n_issue, r_ord, n_ord;
    logic                   r_rd_vld, n_rd_vld;
    logic [COUNT_WIDTH-1:0] r_lo, n_lo, r_hi, n_hi;
    logic [COUNT_WIDTH-1:0] r_eval_sample, n_eval_sample;
    logic                   r_started, n_started;
    logic [15:0]            r_tsb, n_tsb, tsb_inc, interval;
    logic [3:0]             up4, dn4;
    logic [SW-1:0]          lo_ext, hi_ext, min_ext, max_ext, smp_ext;
    logic                   slot_free, ring_we, rd_en, load, first, scan_last;
    logic                   fin_done;
    logic [COUNT_WIDTH-1:0] fin_sample;

    logic                   r_out_valid, n_out_valid;
    logic [1:0]             r_out_state, n_out_state;
    logic [15:0]            r_out_interval, n_out_interval;
    logic                   r_out_beacon, n_out_beacon;
    logic                   r_out_done, n_out_done;
    logic [15:0]            r_out_sample, n_out_sample;

    always_comb begin
        slot_free = !r_out_valid || !i_stall;
        held_inc  = (r_held == HW'(WINDOW_DEPTH)) ? r_held : r_held + HW'(1);
        pos_inc   = (r_pos == PW'(WINDOW_DEPTH - 1)) ? '0 : r_pos + PW'(1);
        up4       = (i_cfg.up_window == 4'd0) ? 4'd1 : i_cfg.up_window;
        dn4       = (i_cfg.down_window == 4'd0) ? 4'd1 : i_cfg.down_window;
        up_len    = (int'(up4) >= int'(held_inc)) ? held_inc : HW'(up4);
        dn_len    = (int'(dn4) >= int'(held_inc)) ? held_inc : HW'(dn4);
        scan_n    = (up_len > dn_len) ? up_len : dn_len;
        scan_last = r_rd_vld && (r_ord == r_scan_n - HW'(1));
    end

    always_comb begin
        lo_ext  = SW'(r_lo);
        hi_ext  = SW'(r_hi);
        min_ext = SW'(i_cfg.min_load_busy);
        max_ext = SW'(i_cfg.max_load_busy);
        eval_state = r_rate_state;
        case (r_rate_state)
            DCC_RELAXED: begin
                if (lo_ext >= min_ext) eval_state = DCC_ACTIVE;
            end
            DCC_RESTRICTED: begin
                if (hi_ext < max_ext) eval_state = DCC_ACTIVE;
            end
            DCC_ACTIVE: begin
                if (hi_ext < min_ext) begin
                    eval_state = DCC_RELAXED;
                end else if (lo_ext >= max_ext) begin
                    eval_state = DCC_RESTRICTED;
                end
            end
            default: eval_state = r_rate_state;
        endcase
    end

    always_comb begin
        n_bk_state = r_bk_state;
        case (r_bk_state)
            BK_IDLE: begin
                if (!i_q_empty && slot_free && (i_q_kind == KIND_EVAL)) n_bk_state = BK_SCAN;
            end
            BK_SCAN: begin
                if (scan_last) n_bk_state = BK_EVAL;
            end
            BK_EVAL: begin
                if (slot_free) n_bk_state = BK_IDLE;
            end
            default: n_bk_state = BK_IDLE;
        endcase
    end

    always_comb begin
        n_rate_state  = r_rate_state;
        n_pos         = r_pos;
        n_held        = r_held;
        n_scan_n      = r_scan_n;
        n_up_len      = r_up_len;
        n_dn_len      = r_dn_len;
        n_issue       = r_issue;
        n_addr        = r_addr;
        n_ord         = r_ord;
        n_rd_vld      = 1'b0;
        n_lo          = r_lo;
        n_hi          = r_hi;
        n_eval_sample = r_eval_sample;
        n_started     = r_started;
        n_tsb         = r_tsb;
        o_q_pop       = 1'b0;
        ring_we       = 1'b0;
        rd_en         = 1'b0;
        load          = 1'b0;
        first         = 1'b0;
        fin_state     = r_rate_state;
        fin_done      = 1'b0;
        fin_sample    = '0;

        case (r_bk_state)
            BK_IDLE: begin
                if (!i_q_empty && slot_free) begin
                    o_q_pop = 1'b1;
                    if (i_q_kind != KIND_TICK) begin
                        ring_we = 1'b1;
                        n_pos   = pos_inc;
                        n_held  = held_inc;
                    end
                    if (i_q_kind == KIND_EVAL) begin
                        n_scan_n      = scan_n;
                        n_up_len      = up_len;
                        n_dn_len      = dn_len;
                        n_issue       = '0;
                        n_addr        = r_pos;
                        n_lo          = '1;
                        n_hi          = '0;
                        n_eval_sample = i_q_sample;
                    end else begin
                        load       = 1'b1;
                        fin_done   = (i_q_kind == KIND_PUSH);
                        fin_sample = (i_q_kind == KIND_PUSH) ? i_q_sample : '0;
                    end
                end
            end
            BK_SCAN: begin
                if (r_issue != r_scan_n) begin
                    rd_en    = 1'b1;
                    n_rd_vld = 1'b1;
                    n_ord    = r_issue;
                    n_issue  = r_issue + HW'(1);
                    n_addr   = (r_addr == '0) ? PW'(WINDOW_DEPTH - 1) : r_addr - PW'(1);
                end
                if (r_rd_vld) begin
                    if ((r_ord < r_up_len) && (r_rd_data < r_lo)) n_lo = r_rd_data;
                    if ((r_ord < r_dn_len) && (r_rd_data > r_hi)) n_hi = r_rd_data;
                end
            end
            BK_EVAL: begin
                if (slot_free) begin
                    load         = 1'b1;
                    first        = !r_started;
                    n_started    = 1'b1;
                    fin_state    = eval_state;
                    n_rate_state = eval_state;
                    fin_done     = 1'b1;
                    fin_sample   = r_eval_sample;
                end
            end
            default: begin
                n_rd_vld = 1'b0;
            end
        endcase

        interval = sel_interval(i_cfg, fin_state);
        tsb_inc  = (r_tsb != 16'hFFFF) ? r_tsb + 16'd1 : r_tsb;
        smp_ext  = SW'(fin_sample);

        n_out_state    = r_out_state;
        n_out_interval = r_out_interval;
        n_out_beacon   = r_out_beacon;
        n_out_done     = r_out_done;
        n_out_sample   = r_out_sample;
        n_out_valid    = (r_out_valid && !i_stall) ? 1'b0 : r_out_valid;

        if (load) begin
            n_out_valid    = 1'b1;
            n_out_state    = 2'(fin_state);
            n_out_interval = interval;
            n_out_done     = fin_done;
            n_out_sample   = smp_ext[15:0];
            n_out_beacon   = 1'b0;
            if (first) begin
                n_out_beacon = 1'b1;
                n_tsb        = 16'd0;
            end else if (r_started) begin
                if (tsb_inc >= interval) begin
                    n_out_beacon = 1'b1;
                    n_tsb        = 16'd0;
                end else begin
                    n_tsb = tsb_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            r_ring[r_pos] <= i_q_sample;
        end
        if (rd_en) begin
            r_rd_data <= r_ring[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bk_state   <= BK_IDLE;
            r_rate_state <= DCC_RELAXED;
            r_pos        <= '0;
            r_held       <= '0;
            r_issue      <= '0;
            r_rd_vld     <= 1'b0;
            r_started    <= 1'b0;
            r_tsb        <= 16'd0;
            r_out_valid  <= 1'b0;
        end else begin
            r_bk_state   <= n_bk_state;
            r_rate_state <= n_rate_state;
            r_pos        <= n_pos;
            r_held       <= n_held;
            r_issue      <= n_issue;
            r_rd_vld     <= n_rd_vld;
            r_started    <= n_started;
            r_tsb        <= n_tsb;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan_n       <= n_scan_n;
        r_up_len       <= n_up_len;
        r_dn_len       <= n_dn_len;
        r_addr         <= n_addr;
        r_ord          <= n_ord;
        r_lo           <= n_lo;
        r_hi           <= n_hi;
        r_eval_sample  <= n_eval_sample;
        r_out_state    <= n_out_state;
        r_out_interval <= n_out_interval;
        r_out_beacon   <= n_out_beacon;
        r_out_done     <= n_out_done;
        r_out_sample   <= n_out_sample;
    end

    assign o_valid           = r_out_valid;
    assign o_dcc_state       = r_out_state;
    assign o_beacon_interval = r_out_interval;
    assign o_beacon_now      = r_out_beacon;
    assign o_measure_done    = r_out_done;
    assign o_busy_sample     = r_out_sample;

endmodule

>>> design/congestion_control_rate_selector_core.sv
`timescale 1ns / 1ps
// Top level of the reactive three-state congestion control rate selector.
// One input beat is one timebase tick with the channel-busy flag; each tick gives one result
// beat with the state, the beacon interval in force, the beacon strobe and, at the end of a
// measurement, the busy count. The front end takes a tick every cycle while its two-entry
// queue has room. The back end retires a plain or measurement-ending tick while its result
// slot is free; a tick that ends a measurement and triggers an evaluation holds the back end
// for a scan of n samples, where n (at most WINDOW_DEPTH) is the larger of the two effective
// window lengths, because the sample ring has a single read port and is scanned one sample per
// cycle. The ring needs no clearing after reset. Configuration writes are always accepted.
module congestion_control_rate_selector_core import ccrs_pkg::*; #(
    parameter int WINDOW_DEPTH = 8,
    parameter int EVAL_EVERY   = 1,
    parameter int COUNT_WIDTH  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_channel_busy,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_dcc_state,
    output logic [15:0] o_beacon_interval,
    output logic        o_beacon_now,
    output logic        o_measure_done,
    output logic [15:0] o_busy_sample,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int QW = KIND_WIDTH + COUNT_WIDTH;

    t_cfg                   r_cfg;
    logic                   push, q_full, q_empty, q_pop;
    t_item_kind             f_kind;
    logic [COUNT_WIDTH-1:0] f_sample;
    logic [QW-1:0]          q_wdata, q_rdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.measure_ticks       <= RST_MEASURE_TICKS;
            r_cfg.up_window           <= RST_UP_WINDOW;
            r_cfg.down_window         <= RST_DOWN_WINDOW;
            r_cfg.min_load_busy       <= RST_MIN_LOAD_BUSY;
            r_cfg.max_load_busy       <= RST_MAX_LOAD_BUSY;
            r_cfg.relaxed_interval    <= RST_RELAXED_INTERVAL;
            r_cfg.active_interval     <= RST_ACTIVE_INTERVAL;
            r_cfg.restricted_interval <= RST_RESTRICTED_INTERVAL;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_IDX_MEASURE_TICKS:       r_cfg.measure_ticks       <= i_cfg_data;
                CFG_IDX_UP_WINDOW:           r_cfg.up_window           <= i_cfg_data[3:0];
                CFG_IDX_DOWN_WINDOW:         r_cfg.down_window         <= i_cfg_data[3:0];
                CFG_IDX_MIN_LOAD_BUSY:       r_cfg.min_load_busy       <= i_cfg_data;
                CFG_IDX_MAX_LOAD_BUSY:       r_cfg.max_load_busy       <= i_cfg_data;
                CFG_IDX_RELAXED_INTERVAL:    r_cfg.relaxed_interval    <= i_cfg_data;
                CFG_IDX_ACTIVE_INTERVAL:     r_cfg.active_interval     <= i_cfg_data;
                CFG_IDX_RESTRICTED_INTERVAL: r_cfg.restricted_interval <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ccrs_front #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .EVAL_EVERY  (EVAL_EVERY)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .i_channel_busy  (i_channel_busy),
        .o_stall         (o_stall),
        .i_measure_ticks (r_cfg.measure_ticks),
        .i_full          (q_full),
        .o_push          (push),
        .o_kind          (f_kind),
        .o_sample        (f_sample)
    );

    assign q_wdata = {f_kind, f_sample};

    ccrs_queue #(
        .WIDTH (QW),
        .DEPTH (2)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty)
    );

    ccrs_back #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (r_cfg),
        .i_q_empty         (q_empty),
        .i_q_kind          (t_item_kind'(q_rdata[QW-1:COUNT_WIDTH])),
        .i_q_sample        (q_rdata[COUNT_WIDTH-1:0]),
        .o_q_pop           (q_pop),
        .i_stall           (i_stall),
        .o_valid           (o_valid),
        .o_dcc_state       (o_dcc_state),
        .o_beacon_interval (o_beacon_interval),
        .o_beacon_now      (o_beacon_now),
        .o_measure_done    (o_measure_done),
        .o_busy_sample     (o_busy_sample)
    );

    a_interval_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_beacon_interval != 16'd0))
        else $error("beacon interval of zero delivered");

    a_sample_only_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_measure_done) |-> (o_busy_sample == 16'd0))
        else $error("busy sample without a finished measurement");

    a_restricted_interval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_dcc_state == DCC_RESTRICTED)) |->
        (o_beacon_interval == sel_interval(r_cfg, DCC_RESTRICTED)))
        else $error("restricted state carries the wrong beacon interval");

endmodule
